>>> hdl/multitrack_stereo_mixer_defines.svh
// assertion macros shared by the mixer files
`ifndef MULTITRACK_STEREO_MIXER_DEFINES_SVH
`define MULTITRACK_STEREO_MIXER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mixer check failed");

// next-cycle implication
`define MSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mixer check failed");

// invariant
`define MSM_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("mixer check failed");

`else

`define MSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`define MSM_ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

>>> hdl/msm_pkg.sv
package msm_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam int GAIN_BITS      = 8;
    localparam int GAIN_REG_BITS  = 40;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 40;

    // datapath widths
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 4;

    // floor division by the gain divisor through a reciprocal multiply
    localparam int MIX_DIV     = 500;
    localparam int OFS_BITS    = SAMPLE_BITS + 9;
    localparam int RECIP_SHIFT = OFS_BITS + 9;
    localparam int RECIP_BITS  = RECIP_SHIFT - 8;
    localparam int MUL_BITS    = OFS_BITS + RECIP_BITS;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + MIX_DIV - 1) / MIX_DIV;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_FULL);

    // mix sums at or above the upper bound, or below the lower one, saturate
    localparam logic signed [SUM_BITS-1:0] SAT_OFFSET =
        SUM_BITS'(longint'(MIX_DIV) <<< (SAMPLE_BITS - 1));
    localparam logic signed [SUM_BITS-1:0] SAT_NEG_OFFSET = -SAT_OFFSET;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FIRST  = 2'd0,
        MODE_SECOND = 2'd1,
        MODE_BOTH   = 2'd2,
        MODE_OFF    = 2'd3
    } t_mix_mode;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MIX_MODE     = 8'd0,
        REG_PAUSE        = 8'd1,
        REG_GAINS_FIRST  = 8'd2,
        REG_GAINS_SECOND = 8'd3
    } t_cfg_reg;

    localparam logic [GAIN_REG_BITS-1:0] GAINS_RESET = 40'h0001010101;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ch0;
        logic signed [SAMPLE_BITS-1:0] ch1;
        logic signed [SAMPLE_BITS-1:0] ch2;
        logic signed [SAMPLE_BITS-1:0] ch3;
        logic signed [SAMPLE_BITS-1:0] ch4;
        logic signed [SAMPLE_BITS-1:0] ch5;
        logic signed [SAMPLE_BITS-1:0] ch6;
        logic signed [SAMPLE_BITS-1:0] ch7;
        logic signed [SAMPLE_BITS-1:0] ch8;
        logic signed [SAMPLE_BITS-1:0] ch10;
        logic signed [SAMPLE_BITS-1:0] ch11;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mix_left;
        logic signed [SAMPLE_BITS-1:0] mix_right;
        logic signed [SAMPLE_BITS-1:0] passthrough;
    } t_out_item;

    // stage enables for the divide and saturate unit
    typedef struct packed {
        logic en_sat;
        logic en_mul;
        logic en_out;
    } t_fin_ctrl;

    // sign-extend one product to the sum width
    function automatic logic signed [SUM_BITS-1:0] f_ext(input logic signed [PROD_BITS-1:0] x);
        return SUM_BITS'(x);
    endfunction

endpackage

>>> hdl/msm_finish.sv
`include "multitrack_stereo_mixer_defines.svh"

// floor(sum / divisor) saturated to a sample, three register stages
module msm_finish (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  msm_pkg::t_fin_ctrl                        i_ctrl,
    input  logic signed [msm_pkg::SUM_BITS-1:0]       i_sum,
    output logic signed [msm_pkg::SAMPLE_BITS-1:0]    o_sample
);

    logic signed [msm_pkg::SUM_BITS-1:0]    n_ofs;
    logic [msm_pkg::OFS_BITS-1:0]           r_ofs;
    logic [msm_pkg::MUL_BITS-1:0]           r_prod;
    logic                                   r_hi_a;
    logic                                   r_lo_a;
    logic                                   r_hi_b;
    logic                                   r_lo_b;
    logic [msm_pkg::SAMPLE_BITS-1:0]        n_quot;
    logic signed [msm_pkg::SAMPLE_BITS-1:0] r_q;

    // shift the in-range sum up so it is never negative
    assign n_ofs  = i_sum + msm_pkg::SAT_OFFSET;
    assign n_quot = r_prod[msm_pkg::RECIP_SHIFT +: msm_pkg::SAMPLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi_a <= 1'b0;
            r_lo_a <= 1'b0;
            r_hi_b <= 1'b0;
            r_lo_b <= 1'b0;
        end else begin
            if (i_ctrl.en_sat) begin
                r_hi_a <= (i_sum >= msm_pkg::SAT_OFFSET);
                r_lo_a <= (i_sum < msm_pkg::SAT_NEG_OFFSET);
            end
            if (i_ctrl.en_mul) begin
                r_hi_b <= r_hi_a;
                r_lo_b <= r_lo_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_sat) begin
            r_ofs <= n_ofs[msm_pkg::OFS_BITS-1:0];
        end
        if (i_ctrl.en_mul) begin
            r_prod <= msm_pkg::MUL_BITS'(r_ofs) * msm_pkg::MUL_BITS'(msm_pkg::RECIP);
        end
        if (i_ctrl.en_out) begin
            if (r_hi_b) begin
                r_q <= msm_pkg::SAMPLE_MAX;
            end else if (r_lo_b) begin
                r_q <= msm_pkg::SAMPLE_MIN;
            end else begin
                // remove the offset: flip the top bit of the quotient
                r_q <= $signed({~n_quot[msm_pkg::SAMPLE_BITS-1],
                                n_quot[msm_pkg::SAMPLE_BITS-2:0]});
            end
        end
    end

    assign o_sample = r_q;

    `MSM_ASSERT_ALWAYS(a_sat_a_excl, i_clk, i_rst_n, $onehot0({r_hi_a, r_lo_a}))
    `MSM_ASSERT_ALWAYS(a_sat_b_excl, i_clk, i_rst_n, $onehot0({r_hi_b, r_lo_b}))
    `MSM_ASSERT_NXT(a_sat_hi_out, i_clk, i_rst_n, i_ctrl.en_out && r_hi_b, r_q == msm_pkg::SAMPLE_MAX)

endmodule

>>> hdl/multitrack_stereo_mixer.sv
// Stereo mixer: each input item is one multichannel frame, each result item
// a left and right mix plus channel 3 unchanged. Gains are 8-bit and weigh
// as g/250, the mix is halved, so every mix is an integer sum divided by 500,
// floored and saturated to a signed sample. Mode 0 mixes the first gain set,
// mode 1 the reduced second set, mode 2 both sets; mode 3 or pause accepts
// items but gives no result for them. The block takes one item per clock while
// o_in_stall is low and has seven register stages: operand register, gain
// multipliers, two adder stages, then saturate check, the reciprocal multiply
// that replaces the divide, and the output register.
// Stalls only hold stages that carry an item; empty stages keep filling, so
// o_in_stall rises only when every stage is full and the output is stalled.
// Configuration writes are always ready and must only happen while no item
// is in flight.

`include "multitrack_stereo_mixer_defines.svh"

module multitrack_stereo_mixer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // item in
    input  logic                                    i_in_valid,
    input  msm_pkg::t_in_item                       i_in_item,
    output logic                                    o_in_stall,
    // item out
    output logic                                    o_out_valid,
    output msm_pkg::t_out_item                      o_out_item,
    input  logic                                    i_out_stall,
    // configuration writes
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [msm_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  logic [msm_pkg::CFG_DATA_BITS-1:0]       i_cfg_data
);

    localparam int NST = 7;   // pipeline depth
    localparam int GB  = msm_pkg::GAIN_BITS;

    // ---------------- configuration registers ----------------
    msm_pkg::t_mix_mode                    r_mix_mode;
    logic                                  r_pause;
    logic [msm_pkg::GAIN_REG_BITS-1:0]     r_gains_first;
    logic [msm_pkg::GAIN_REG_BITS-1:0]     r_gains_second;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_mode     <= msm_pkg::MODE_SECOND;
            r_pause        <= 1'b0;
            r_gains_first  <= msm_pkg::GAINS_RESET;
            r_gains_second <= msm_pkg::GAINS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                msm_pkg::REG_MIX_MODE: begin
                    r_mix_mode <= msm_pkg::t_mix_mode'(i_cfg_data[msm_pkg::MODE_BITS-1:0]);
                end
                msm_pkg::REG_PAUSE: begin
                    r_pause <= i_cfg_data[0];
                end
                msm_pkg::REG_GAINS_FIRST: begin
                    r_gains_first <= i_cfg_data[msm_pkg::GAIN_REG_BITS-1:0];
                end
                msm_pkg::REG_GAINS_SECOND: begin
                    r_gains_second <= i_cfg_data[msm_pkg::GAIN_REG_BITS-1:0];
                end
                default: begin
                    // unknown register: write dropped
                end
            endcase
        end
    end

    // gain fields, low byte first
    logic [GB-1:0] w_g1, w_g2, w_g3, w_g4, w_k1;
    logic [GB-1:0] w_g7, w_g8, w_g9, w_g10, w_k2;
    logic [GB-1:0] w_ga, w_gb;

    assign w_g1  = r_gains_first[0*GB +: GB];
    assign w_g2  = r_gains_first[1*GB +: GB];
    assign w_g3  = r_gains_first[2*GB +: GB];
    assign w_g4  = r_gains_first[3*GB +: GB];
    assign w_k1  = r_gains_first[4*GB +: GB];
    assign w_g7  = r_gains_second[0*GB +: GB];
    assign w_g8  = r_gains_second[1*GB +: GB];
    assign w_g9  = r_gains_second[2*GB +: GB];
    assign w_g10 = r_gains_second[3*GB +: GB];
    assign w_k2  = r_gains_second[4*GB +: GB];

    // the original and beat weights switch sets in mode 1
    assign w_ga = (r_mix_mode == msm_pkg::MODE_SECOND) ? w_g7 : w_g1;
    assign w_gb = (r_mix_mode == msm_pkg::MODE_SECOND) ? w_g8 : w_g2;

    logic w_m0, w_m2;
    assign w_m0 = (r_mix_mode == msm_pkg::MODE_FIRST);
    assign w_m2 = (r_mix_mode == msm_pkg::MODE_BOTH);

    // ---------------- pipeline control ----------------
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;
    logic           w_in_acc;
    logic           w_in_live;

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || !i_out_stall;
        for (int i = NST - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign o_in_stall = !w_en[0];
    assign w_in_acc   = i_in_valid && !o_in_stall;
    // muted items are taken but leave a bubble
    assign w_in_live  = w_in_acc && !r_pause && (r_mix_mode != msm_pkg::MODE_OFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= w_in_live;
            end
            for (int i = 1; i < NST; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // ---------------- stage 0: operands and karaoke differences ----------------
    msm_pkg::t_in_item                          r_s0_item;
    logic signed [msm_pkg::DIFF_BITS-1:0]       r_s0_d01;
    logic signed [msm_pkg::DIFF_BITS-1:0]       r_s0_d67;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_item <= i_in_item;
            r_s0_d01  <= msm_pkg::DIFF_BITS'(i_in_item.ch0) - msm_pkg::DIFF_BITS'(i_in_item.ch1);
            r_s0_d67  <= msm_pkg::DIFF_BITS'(i_in_item.ch6) - msm_pkg::DIFF_BITS'(i_in_item.ch7);
        end
    end

    // ---------------- stage 1: gain products ----------------
    logic signed [msm_pkg::PROD_BITS-1:0] r_p_a_l, r_p_a_r, r_p_b, r_p_c4, r_p_c5, r_p_k1;
    logic signed [msm_pkg::PROD_BITS-1:0] r_p_c6, r_p_c7, r_p_c8, r_p_c10, r_p_c11, r_p_k2;
    logic signed [msm_pkg::SAMPLE_BITS-1:0] r_pt1;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_p_a_l <= $signed({1'b0, w_ga})  * r_s0_item.ch0;
            r_p_a_r <= $signed({1'b0, w_ga})  * r_s0_item.ch1;
            r_p_b   <= $signed({1'b0, w_gb})  * r_s0_item.ch2;
            r_p_c4  <= $signed({1'b0, w_g3})  * r_s0_item.ch4;
            r_p_c5  <= $signed({1'b0, w_g4})  * r_s0_item.ch5;
            r_p_k1  <= $signed({1'b0, w_k1})  * r_s0_d01;
            r_p_c6  <= $signed({1'b0, w_g7})  * r_s0_item.ch6;
            r_p_c7  <= $signed({1'b0, w_g7})  * r_s0_item.ch7;
            r_p_c8  <= $signed({1'b0, w_g8})  * r_s0_item.ch8;
            r_p_c10 <= $signed({1'b0, w_g9})  * r_s0_item.ch10;
            r_p_c11 <= $signed({1'b0, w_g10}) * r_s0_item.ch11;
            r_p_k2  <= $signed({1'b0, w_k2})  * r_s0_d67;
            r_pt1   <= r_s0_item.ch3;
        end
    end

    // ---------------- stage 2: partial sums by mode ----------------
    localparam logic signed [msm_pkg::SUM_BITS-1:0] SUM_ZERO = '0;

    logic signed [msm_pkg::SUM_BITS-1:0] n_k1_term;
    logic signed [msm_pkg::SUM_BITS-1:0] r_com1, r_com2, r_lx, r_rx;
    logic signed [msm_pkg::SAMPLE_BITS-1:0] r_pt2;

    // first karaoke term is doubled only in mode 0
    assign n_k1_term = w_m0 ? (msm_pkg::f_ext(r_p_k1) <<< 1) : msm_pkg::f_ext(r_p_k1);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            // drum, harmonic and karaoke of the first set: modes 0 and 2
            r_com1 <= (w_m0 || w_m2)
                    ? msm_pkg::f_ext(r_p_c4) + msm_pkg::f_ext(r_p_c5) + n_k1_term
                    : SUM_ZERO;
            // shared second-set terms: mode 2 only
            r_com2 <= w_m2
                    ? msm_pkg::f_ext(r_p_c10) + msm_pkg::f_ext(r_p_c11) + msm_pkg::f_ext(r_p_k2)
                    : SUM_ZERO;
            // left keeps its beat term, adds the second original left in mode 2
            r_lx   <= msm_pkg::f_ext(r_p_a_l) + msm_pkg::f_ext(r_p_b)
                    + (w_m2 ? msm_pkg::f_ext(r_p_c6) : SUM_ZERO);
            // right drops the first beat term in mode 2 and takes the second original right and beat
            r_rx   <= msm_pkg::f_ext(r_p_a_r)
                    + (w_m2 ? msm_pkg::f_ext(r_p_c7) + msm_pkg::f_ext(r_p_c8)
                            : msm_pkg::f_ext(r_p_b));
            r_pt2  <= r_pt1;
        end
    end

    // ---------------- stage 3: full mix sums ----------------
    logic signed [msm_pkg::SUM_BITS-1:0] r_sum_l, r_sum_r;
    logic signed [msm_pkg::SAMPLE_BITS-1:0] r_pt3;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_sum_l <= r_lx + r_com1 + r_com2;
            r_sum_r <= r_rx + r_com1 + r_com2;
            r_pt3   <= r_pt2;
        end
    end

    // ---------------- stages 4 to 6: divide, floor, saturate ----------------
    msm_pkg::t_fin_ctrl w_fin_ctrl;
    logic signed [msm_pkg::SAMPLE_BITS-1:0] w_mix_l, w_mix_r;
    logic signed [msm_pkg::SAMPLE_BITS-1:0] r_pt4, r_pt5, r_pt6;

    assign w_fin_ctrl.en_sat = w_en[4];
    assign w_fin_ctrl.en_mul = w_en[5];
    assign w_fin_ctrl.en_out = w_en[6];

    msm_finish u_fin_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_fin_ctrl),
        .i_sum    (r_sum_l),
        .o_sample (w_mix_l)
    );

    msm_finish u_fin_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_fin_ctrl),
        .i_sum    (r_sum_r),
        .o_sample (w_mix_r)
    );

    // pass-through channel rides along with the mix
    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_pt4 <= r_pt3;
        end
        if (w_en[5]) begin
            r_pt5 <= r_pt4;
        end
        if (w_en[6]) begin
            r_pt6 <= r_pt5;
        end
    end

    assign o_out_valid            = r_v[NST-1];
    assign o_out_item.mix_left    = w_mix_l;
    assign o_out_item.mix_right   = w_mix_r;
    assign o_out_item.passthrough = r_pt6;

    // muted items never enter the pipeline
    `MSM_ASSERT_NXT(a_muted_drop, i_clk, i_rst_n, w_in_acc && (r_pause || r_mix_mode == msm_pkg::MODE_OFF), !r_v[0])
    // input stalls only when no bubble is left to fill
    `MSM_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_in_stall, &r_v)
    // a stalled result item stays in the output stage
    `MSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_v[NST-1] && i_out_stall, r_v[NST-1])

endmodule

>>> tb/sv/tb_multitrack_stereo_mixer.sv
`timescale 1ns / 100ps

module tb_multitrack_stereo_mixer;

    // the mix divisor: gain/250, then halved
    localparam longint MIX_DIVISOR     = 500;
    // pipeline depth plus margin, waited out before any register write
    localparam int     DRAIN_CYCLES    = 12;
    // cycles with no handshake of any kind before the run is declared hung
    localparam int     WATCHDOG_CYCLES = 1000;
    localparam int     REPORT_LIMIT    = 10;
    localparam int     RANDOM_PHASES   = 12;
    localparam int     ITEMS_PER_PHASE = 35;
    localparam int     DIRECTED_FRAMES = 5;

    // dut inputs, all known from time zero
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_in_valid  = 1'b0;
    msm_pkg::t_in_item                  i_in_item   = '0;
    logic                               i_out_stall = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic [msm_pkg::CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [msm_pkg::CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    // dut outputs
    logic               o_in_stall;
    logic               o_out_valid;
    msm_pkg::t_out_item o_out_item;
    logic               o_cfg_ready;

    // shadow copy of the mixer registers, reset values
    msm_pkg::t_mix_mode                mode_cfg         = msm_pkg::MODE_SECOND;
    logic                              pause_cfg        = 1'b0;
    logic [msm_pkg::GAIN_REG_BITS-1:0] gains_first_cfg  = msm_pkg::GAINS_RESET;
    logic [msm_pkg::GAIN_REG_BITS-1:0] gains_second_cfg = msm_pkg::GAINS_RESET;

    msm_pkg::t_in_item  frames_to_send[$];
    msm_pkg::t_out_item mixes_due[$];

    logic in_took      = 1'b0;
    bit   idle_on      = 1'b1;
    int   in_gap       = 0;
    int   out_gap      = 0;
    int   quiet_cycles = 0;
    int   fail_count   = 0;

    multitrack_stereo_mixer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // floor toward minus infinity, then clamp to a signed sample
    function automatic logic signed [msm_pkg::SAMPLE_BITS-1:0] floor_sat(input longint s);
        longint q;
        q = s / MIX_DIVISOR;
        if (s % MIX_DIVISOR != 0 && s < 0)
            q = q - 1;
        if (q > msm_pkg::SAMPLE_MAX)
            q = msm_pkg::SAMPLE_MAX;
        if (q < msm_pkg::SAMPLE_MIN)
            q = msm_pkg::SAMPLE_MIN;
        return q[msm_pkg::SAMPLE_BITS-1:0];
    endfunction

    // expected mix for one frame under the current registers; 0 when no item is due
    function automatic bit mix_frame(input msm_pkg::t_in_item f,
                                     output msm_pkg::t_out_item r);
        longint c0, c1, c2, c4, c5, c6, c7, c8, c10, c11;
        longint g1, g2, g3, g4, k1, g7, g8, g9, g10, k2;
        longint mix_l, mix_r, shared;
        c0  = f.ch0;  c1  = f.ch1;  c2  = f.ch2;  c4  = f.ch4;  c5  = f.ch5;
        c6  = f.ch6;  c7  = f.ch7;  c8  = f.ch8;  c10 = f.ch10; c11 = f.ch11;
        g1  = gains_first_cfg[7:0];    g2  = gains_first_cfg[15:8];
        g3  = gains_first_cfg[23:16];  g4  = gains_first_cfg[31:24];
        k1  = gains_first_cfg[39:32];
        g7  = gains_second_cfg[7:0];   g8  = gains_second_cfg[15:8];
        g9  = gains_second_cfg[23:16]; g10 = gains_second_cfg[31:24];
        k2  = gains_second_cfg[39:32];
        r = '0;
        if (pause_cfg || mode_cfg == msm_pkg::MODE_OFF)
            return 1'b0;
        case (mode_cfg)
            msm_pkg::MODE_FIRST: begin
                // karaoke term doubled, shared by both sides
                shared = g2 * c2 + g3 * c4 + g4 * c5 + 2 * k1 * (c0 - c1);
                mix_l  = g1 * c0 + shared;
                mix_r  = g1 * c1 + shared;
            end
            msm_pkg::MODE_SECOND: begin
                mix_l = g7 * c0 + g8 * c2;
                mix_r = g7 * c1 + g8 * c2;
            end
            default: begin
                // both sets: left lacks the second beat, right lacks the first
                shared = g3 * c4 + g4 * c5 + k1 * (c0 - c1)
                       + g9 * c10 + g10 * c11 + k2 * (c6 - c7);
                mix_l  = g1 * c0 + g2 * c2 + g7 * c6 + shared;
                mix_r  = g1 * c1 + g7 * c7 + g8 * c8 + shared;
            end
        endcase
        r.mix_left    = floor_sat(mix_l);
        r.mix_right   = floor_sat(mix_r);
        r.passthrough = f.ch3;
        return 1'b1;
    endfunction

    // one register write; shadow copy follows at the accepting edge
    task automatic write_reg(input logic [msm_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [msm_pkg::CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            msm_pkg::REG_MIX_MODE:
                mode_cfg = msm_pkg::t_mix_mode'(data[msm_pkg::MODE_BITS-1:0]);
            msm_pkg::REG_PAUSE:
                pause_cfg = data[0];
            msm_pkg::REG_GAINS_FIRST:
                gains_first_cfg = data[msm_pkg::GAIN_REG_BITS-1:0];
            msm_pkg::REG_GAINS_SECOND:
                gains_second_cfg = data[msm_pkg::GAIN_REG_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait until every item is in, every mix is out, and the pipe is empty
    task automatic settle();
        while (frames_to_send.size() != 0 || i_in_valid || mixes_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [msm_pkg::CFG_DATA_BITS-1:0] rand_word();
        return msm_pkg::CFG_DATA_BITS'({$urandom, $urandom});
    endfunction

    // per byte: off, full, random, or tiny
    function automatic logic [msm_pkg::GAIN_REG_BITS-1:0] rand_gains();
        logic [msm_pkg::GAIN_REG_BITS-1:0] g;
        int k;
        for (k = 0; k < msm_pkg::GAIN_REG_BITS / msm_pkg::GAIN_BITS; k++) begin
            case ($urandom_range(0, 3))
                0:       g[msm_pkg::GAIN_BITS*k +: msm_pkg::GAIN_BITS] = '0;
                1:       g[msm_pkg::GAIN_BITS*k +: msm_pkg::GAIN_BITS] = '1;
                2:       g[msm_pkg::GAIN_BITS*k +: msm_pkg::GAIN_BITS] =
                             msm_pkg::GAIN_BITS'($urandom);
                default: g[msm_pkg::GAIN_BITS*k +: msm_pkg::GAIN_BITS] =
                             msm_pkg::GAIN_BITS'($urandom_range(1, 4));
            endcase
        end
        return g;
    endfunction

    // narrow frames keep the mix in range so the floor is visible
    function automatic msm_pkg::t_in_item rand_frame(input bit narrow);
        msm_pkg::t_in_item f;
        int k;
        for (k = 0; k < $bits(msm_pkg::t_in_item) / msm_pkg::SAMPLE_BITS; k++) begin
            if (narrow)
                f[msm_pkg::SAMPLE_BITS*k +: msm_pkg::SAMPLE_BITS] =
                    msm_pkg::SAMPLE_BITS'(int'($urandom_range(0, 4000)) - 2000);
            else if ($urandom_range(0, 7) == 0)
                f[msm_pkg::SAMPLE_BITS*k +: msm_pkg::SAMPLE_BITS] =
                    $urandom_range(0, 1) ? msm_pkg::SAMPLE_MAX : msm_pkg::SAMPLE_MIN;
            else
                f[msm_pkg::SAMPLE_BITS*k +: msm_pkg::SAMPLE_BITS] =
                    msm_pkg::SAMPLE_BITS'($urandom);
        end
        // pass-through channel always sweeps the full range
        f.ch3 = msm_pkg::SAMPLE_BITS'($urandom);
        return f;
    endfunction

    // extremes: all high, all low, silence, karaoke difference at both limits
    function automatic msm_pkg::t_in_item directed_frame(input int n);
        msm_pkg::t_in_item f;
        case (n)
            0:       f = {($bits(msm_pkg::t_in_item) / msm_pkg::SAMPLE_BITS){msm_pkg::SAMPLE_MAX}};
            1:       f = {($bits(msm_pkg::t_in_item) / msm_pkg::SAMPLE_BITS){msm_pkg::SAMPLE_MIN}};
            2:       f = '0;
            3: begin
                f = rand_frame(1'b1);
                f.ch0 = msm_pkg::SAMPLE_MAX; f.ch6 = msm_pkg::SAMPLE_MAX;
                f.ch1 = msm_pkg::SAMPLE_MIN; f.ch7 = msm_pkg::SAMPLE_MIN;
            end
            default: begin
                f = rand_frame(1'b1);
                f.ch0 = msm_pkg::SAMPLE_MIN; f.ch6 = msm_pkg::SAMPLE_MIN;
                f.ch1 = msm_pkg::SAMPLE_MAX; f.ch7 = msm_pkg::SAMPLE_MAX;
                f.ch3 = 16'h5a5a;
            end
        endcase
        return f;
    endfunction

    // input driver: holds an item until taken, idles in bursts of random length
    always @(negedge i_clk) begin
        if (!i_in_valid || in_took) begin
            if (in_gap != 0) begin
                in_gap     <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (!i_rst_n || frames_to_send.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                in_gap     <= $urandom_range(0, 8);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_item  <= frames_to_send[0];
            end
        end
    end

    // output side back-pressure, same burst shape
    always @(negedge i_clk) begin
        if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_gap     <= $urandom_range(0, 8);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: predict at input acceptance, compare at output acceptance
    always @(posedge i_clk) begin : monitor
        msm_pkg::t_out_item predicted;
        msm_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                void'(frames_to_send.pop_front());
                if (mix_frame(i_in_item, predicted))
                    mixes_due.push_back(predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (mixes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected item L=%0d R=%0d P=%0d", $time,
                                 o_out_item.mix_left, o_out_item.mix_right,
                                 o_out_item.passthrough);
                end else begin
                    want = mixes_due.pop_front();
                    if (want.mix_left !== o_out_item.mix_left ||
                        want.mix_right !== o_out_item.mix_right ||
                        want.passthrough !== o_out_item.passthrough) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: mismatch exp L=%0d R=%0d P=%0d got L=%0d R=%0d P=%0d",
                                     $time, want.mix_left, want.mix_right, want.passthrough,
                                     o_out_item.mix_left, o_out_item.mix_right,
                                     o_out_item.passthrough);
                    end
                end
            end
        end
        in_took <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // hang detection: any handshake resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        msm_pkg::t_mix_mode                dir_mode[5];
        logic                              dir_pause[5];
        logic [msm_pkg::CFG_DATA_BITS-1:0] word;
        int                                ph, n, r;
        dir_mode  = '{msm_pkg::MODE_FIRST, msm_pkg::MODE_SECOND, msm_pkg::MODE_BOTH,
                      msm_pkg::MODE_OFF, msm_pkg::MODE_FIRST};
        dir_pause = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: second set reduced, unit gains
        frames_to_send.push_back(rand_frame(1'b1));
        frames_to_send.push_back(rand_frame(1'b0));
        settle();

        // directed: full gains, every mode, mode three and pause give nothing
        for (ph = 0; ph < 5; ph++) begin
            write_reg(msm_pkg::REG_GAINS_FIRST, '1);
            write_reg(msm_pkg::REG_GAINS_SECOND, '1);
            write_reg(msm_pkg::REG_MIX_MODE, msm_pkg::CFG_DATA_BITS'(dir_mode[ph]));
            write_reg(msm_pkg::REG_PAUSE, msm_pkg::CFG_DATA_BITS'(dir_pause[ph]));
            for (n = 0; n < DIRECTED_FRAMES; n++)
                frames_to_send.push_back(directed_frame(n));
            settle();
        end

        // random phases; the last one runs without idling on either side
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 9);
            // upper bits of the narrow registers are junk and must be dropped
            word = rand_word();
            word[msm_pkg::MODE_BITS-1:0] =
                (r < 3) ? msm_pkg::MODE_FIRST :
                (r < 6) ? msm_pkg::MODE_SECOND :
                (r < 9 || ph == RANDOM_PHASES - 1) ? msm_pkg::MODE_BOTH : msm_pkg::MODE_OFF;
            write_reg(msm_pkg::REG_MIX_MODE, word);
            word = rand_word();
            word[0] = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 7) == 0);
            write_reg(msm_pkg::REG_PAUSE, word);
            write_reg(msm_pkg::REG_GAINS_FIRST,
                      (ph == 1) ? '0 : msm_pkg::CFG_DATA_BITS'(rand_gains()));
            write_reg(msm_pkg::REG_GAINS_SECOND, msm_pkg::CFG_DATA_BITS'(rand_gains()));
            // writes to an index past the register map change nothing
            if ($urandom_range(0, 2) == 0)
                write_reg(msm_pkg::CFG_INDEX_BITS'($urandom_range(4, 255)), rand_word());
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                frames_to_send.push_back(rand_frame($urandom_range(0, 2) == 0));
            settle();
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
